// ----- hw/rtl/vaps_pkg.sv -----
// shared constants, codes and types of the voice allocator
`default_nettype none

package vaps_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int ID_WIDTH  = 32;
  localparam int NUM_CATS  = 7;

  localparam int VID_W     = 32;
  localparam int PRIO_W    = 16;
  localparam int CAT_W     = 3;
  localparam int MAX_W     = 7;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 4;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ISS_W = IDX_W + 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W = (CNT_W > MAX_W) ? CNT_W : MAX_W;

  localparam logic [MAX_W-1:0] MAX_RESET [NUM_CATS] = '{
    7'd10, 7'd5, 7'd15, 7'd20, 7'd10, 7'd3, 7'd5
  };
  localparam logic [NUM_CATS-1:0] ENABLE_RESET = {NUM_CATS{1'b1}};
  localparam logic [ID_WIDTH-1:0] ID_FIRST     = ID_WIDTH'(1);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(NUM_CATS);

  typedef enum logic [1:0] {
    FUNC_PLAY     = 2'd0,
    FUNC_RELEASE  = 2'd1,
    FUNC_STOP_CAT = 2'd2,
    FUNC_STOP_ALL = 2'd3
  } func_e;

  localparam logic [KIND_W-1:0] KIND_GRANT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_END,
    ST_GRANT
  } state_e;

  typedef struct packed {
    logic [CAT_W-1:0]    cat;
    logic [PRIO_W-1:0]   prio;
    logic [ID_WIDTH-1:0] id;
  } slot_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/voice_allocator_priority_steal.sv -----
// top level of the voice allocator with priority stealing
`default_nettype none

// Voice slot allocator. Slot entries (category, priority, id) live in a
// synchronous RAM with a registered read port; the per-slot valid bits,
// the per-category voice counts and the id counter are flops. Every command
// (play, release, stop category, stop all) sweeps the RAM once, one slot per
// cycle while the sweep is not paused. An item is accepted, swept in a
// pipeline (the reads of all slots, the compare of the last slot and a
// drain step), decided and, for a grant, the voice is written back. A steal
// emits the freed voice's completion and then the grant. Stop commands emit
// one completion per freed voice, the last one after the sweep; the sweep
// pauses whenever a completion is ready but the output register is still
// held by the consumer, so a stalled output slows the sweep. The RAM is
// written only after the sweep has ended, so reads and writes of the same
// entry never overlap. No clearing pass is needed after reset: the valid
// bits start cleared. Config writes are taken at any time, with cfg_ready_o
// always high.
module voice_allocator_priority_steal (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // command channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [1:0]                         func_i,
  input  wire logic [vaps_pkg::CAT_W-1:0]         category_i,
  input  wire logic [vaps_pkg::PRIO_W-1:0]        priority_req_i,
  input  wire logic [vaps_pkg::VID_W-1:0]         voice_id_i,
  // result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [vaps_pkg::KIND_W-1:0]        kind_o,
  output logic      [vaps_pkg::VID_W-1:0]         voice_id_res_o,
  output logic      [vaps_pkg::CAT_W-1:0]         category_res_o,
  output logic                                    last_o,
  // config write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [vaps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [vaps_pkg::MAX_W-1:0]         cfg_data_i
);

  import vaps_pkg::*;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // config registers
  logic [MAX_W-1:0]    max_q [NUM_CATS];
  logic [NUM_CATS-1:0] enable_q;

  // control state
  state_e              state_q, state_d;
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]    cnt_q [NUM_CATS];
  logic [CNT_W-1:0]    cnt_d [NUM_CATS];
  logic [ID_WIDTH-1:0] next_id_q, next_id_d;

  // captured command
  func_e               func_q, func_d;
  logic [CAT_W-1:0]    cat_q, cat_d;
  logic [PRIO_W-1:0]   prio_q, prio_d;
  logic [VID_W-1:0]    vid_q, vid_d;

  // sweep pipeline: issue counter and data stage
  logic [ISS_W-1:0]    iss_q, iss_d;
  logic                d_vld_q, d_vld_d;
  logic [IDX_W-1:0]    d_idx_q, d_idx_d;

  // play search results
  logic [PRIO_W-1:0]   best_q, best_d;
  logic                vic_vld_q, vic_vld_d;
  logic [IDX_W-1:0]    vic_idx_q, vic_idx_d;
  logic [ID_WIDTH-1:0] vic_id_q, vic_id_d;
  logic                free_vld_q, free_vld_d;
  logic [IDX_W-1:0]    free_idx_q, free_idx_d;

  // release search result
  logic                fnd_vld_q, fnd_vld_d;
  logic [IDX_W-1:0]    fnd_idx_q, fnd_idx_d;
  logic [ID_WIDTH-1:0] fnd_id_q, fnd_id_d;
  logic [CAT_W-1:0]    fnd_cat_q, fnd_cat_d;

  // stop: one completion held back until we know whether it is the last one
  logic                pend_vld_q, pend_vld_d;
  logic [ID_WIDTH-1:0] pend_id_q, pend_id_d;
  logic [CAT_W-1:0]    pend_cat_q, pend_cat_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [KIND_W-1:0]   out_kind_q, out_kind_d;
  logic [VID_W-1:0]    out_id_q, out_id_d;
  logic [CAT_W-1:0]    out_cat_q, out_cat_d;
  logic                out_last_q, out_last_d;

  // ram port
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  slot_entry_t         rd_entry, wr_entry;

  // helpers
  logic                out_free;
  logic                out_load;
  logic                stall;
  logic                hit_vld;
  logic                stop_hit;
  logic                cat_ok;
  logic                cat_en;
  logic                cat_full;
  logic [CNT_W-1:0]    cnt_sel;
  logic [MAX_W-1:0]    max_sel;
  logic                iss_done;

  vaps_ram #(
    .DEPTH(NUM_SLOTS),
    .WIDTH(ENTRY_W)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry  = slot_entry_t'(ram_rdata);
  assign ram_wdata = ENTRY_W'(wr_entry);

  assign in_ready_o     = (state_q == ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign voice_id_res_o = out_id_q;
  assign category_res_o = out_cat_q;
  assign last_o         = out_last_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign hit_vld  = valid_q[d_idx_q];
  assign iss_done = (iss_q == ISS_W'(NUM_SLOTS));
  assign stop_hit = hit_vld && (func_q == FUNC_STOP_ALL || rd_entry.cat == cat_q);

  // a stop completion can only leave once the held one has a free output
  assign stall = (state_q == ST_SCAN) && d_vld_q &&
                 (func_q == FUNC_STOP_CAT || func_q == FUNC_STOP_ALL) &&
                 stop_hit && pend_vld_q && !out_free;

  // requested category lookups, guarded against the unused code seven
  assign cat_ok   = (cat_q < CAT_W'(NUM_CATS));
  assign cat_en   = cat_ok && enable_q[cat_q];
  assign cnt_sel  = cat_ok ? cnt_q[cat_q] : '0;
  assign max_sel  = cat_ok ? max_q[cat_q] : '0;
  assign cat_full = (CMP_W'(cnt_sel) >= CMP_W'(max_sel));

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= MAX_RESET;
      enable_q <= ENABLE_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i < CFG_IDX_W'(NUM_CATS)) begin
        max_q[cfg_index_i[CAT_W-1:0]] <= cfg_data_i;
      end else if (cfg_index_i == REG_ENABLE) begin
        enable_q <= cfg_data_i[NUM_CATS-1:0];
      end
    end
  end

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    cnt_d       = cnt_q;
    next_id_d   = next_id_q;
    func_d      = func_q;
    cat_d       = cat_q;
    prio_d      = prio_q;
    vid_d       = vid_q;
    iss_d       = iss_q;
    d_vld_d     = d_vld_q;
    d_idx_d     = d_idx_q;
    best_d      = best_q;
    vic_vld_d   = vic_vld_q;
    vic_idx_d   = vic_idx_q;
    vic_id_d    = vic_id_q;
    free_vld_d  = free_vld_q;
    free_idx_d  = free_idx_q;
    fnd_vld_d   = fnd_vld_q;
    fnd_idx_d   = fnd_idx_q;
    fnd_id_d    = fnd_id_q;
    fnd_cat_d   = fnd_cat_q;
    pend_vld_d  = pend_vld_q;
    pend_id_d   = pend_id_q;
    pend_cat_d  = pend_cat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_cat_d   = out_cat_q;
    out_last_d  = out_last_q;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = free_idx_q;
    ram_re      = 1'b0;
    ram_raddr   = iss_q[IDX_W-1:0];
    wr_entry.cat  = cat_q;
    wr_entry.prio = prio_q;
    wr_entry.id   = next_id_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d     = func_e'(func_i);
          cat_d      = category_i;
          prio_d     = priority_req_i;
          vid_d      = voice_id_i;
          iss_d      = '0;
          d_vld_d    = 1'b0;
          best_d     = priority_req_i;
          vic_vld_d  = 1'b0;
          free_vld_d = 1'b0;
          fnd_vld_d  = 1'b0;
          pend_vld_d = 1'b0;
          state_d    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (d_vld_q && !stall) begin
          unique case (func_q)
            FUNC_PLAY: begin
              if (hit_vld && rd_entry.cat == cat_q && rd_entry.prio < best_q) begin
                best_d    = rd_entry.prio;
                vic_vld_d = 1'b1;
                vic_idx_d = d_idx_q;
                vic_id_d  = rd_entry.id;
              end
              if (!hit_vld && !free_vld_q) begin
                free_vld_d = 1'b1;
                free_idx_d = d_idx_q;
              end
            end
            FUNC_RELEASE: begin
              if (hit_vld && VID_W'(rd_entry.id) == vid_q && !fnd_vld_q) begin
                fnd_vld_d = 1'b1;
                fnd_idx_d = d_idx_q;
                fnd_id_d  = rd_entry.id;
                fnd_cat_d = rd_entry.cat;
              end
            end
            FUNC_STOP_CAT, FUNC_STOP_ALL: begin
              if (stop_hit) begin
                if (pend_vld_q) begin
                  out_load   = 1'b1;
                  out_kind_d = KIND_DONE;
                  out_id_d   = VID_W'(pend_id_q);
                  out_cat_d  = pend_cat_q;
                  out_last_d = 1'b0;
                end
                pend_vld_d       = 1'b1;
                pend_id_d        = rd_entry.id;
                pend_cat_d       = rd_entry.cat;
                valid_d[d_idx_q] = 1'b0;
                if (rd_entry.cat < CAT_W'(NUM_CATS) && cnt_q[rd_entry.cat] != '0) begin
                  cnt_d[rd_entry.cat] = cnt_q[rd_entry.cat] - CNT_W'(1);
                end
              end
            end
            default: ;
          endcase
        end
        if (!stall) begin
          if (!iss_done) begin
            ram_re  = 1'b1;
            iss_d   = iss_q + ISS_W'(1);
            d_vld_d = 1'b1;
            d_idx_d = iss_q[IDX_W-1:0];
          end else begin
            d_vld_d = 1'b0;
            if (!d_vld_q) begin
              state_d = ST_END;
            end
          end
        end
      end

      ST_END: begin
        unique case (func_q)
          FUNC_PLAY: begin
            if (!cat_en || (cat_full && !vic_vld_q) || (!cat_full && !free_vld_q)) begin
              if (out_free) begin
                out_load   = 1'b1;
                out_kind_d = KIND_REJECT;
                out_id_d   = '0;
                out_cat_d  = cat_q;
                out_last_d = 1'b1;
                state_d    = ST_IDLE;
              end
            end else if (cat_full) begin
              // steal: report the victim, then take the lowest free slot
              if (out_free) begin
                out_load           = 1'b1;
                out_kind_d         = KIND_DONE;
                out_id_d           = VID_W'(vic_id_q);
                out_cat_d          = cat_q;
                out_last_d         = 1'b0;
                valid_d[vic_idx_q] = 1'b0;
                if (cnt_sel != '0) begin
                  cnt_d[cat_q] = cnt_sel - CNT_W'(1);
                end
                if (!free_vld_q || vic_idx_q < free_idx_q) begin
                  free_vld_d = 1'b1;
                  free_idx_d = vic_idx_q;
                end
                state_d = ST_GRANT;
              end
            end else begin
              state_d = ST_GRANT;
            end
          end
          FUNC_RELEASE: begin
            if (!fnd_vld_q) begin
              state_d = ST_IDLE;
            end else if (out_free) begin
              out_load           = 1'b1;
              out_kind_d         = KIND_DONE;
              out_id_d           = VID_W'(fnd_id_q);
              out_cat_d          = fnd_cat_q;
              out_last_d         = 1'b1;
              valid_d[fnd_idx_q] = 1'b0;
              if (fnd_cat_q < CAT_W'(NUM_CATS) && cnt_q[fnd_cat_q] != '0) begin
                cnt_d[fnd_cat_q] = cnt_q[fnd_cat_q] - CNT_W'(1);
              end
              state_d = ST_IDLE;
            end
          end
          FUNC_STOP_CAT, FUNC_STOP_ALL: begin
            if (!pend_vld_q) begin
              state_d = ST_IDLE;
            end else if (out_free) begin
              out_load   = 1'b1;
              out_kind_d = KIND_DONE;
              out_id_d   = VID_W'(pend_id_q);
              out_cat_d  = pend_cat_q;
              out_last_d = 1'b1;
              pend_vld_d = 1'b0;
              state_d    = ST_IDLE;
            end
          end
          default: ;
        endcase
      end

      ST_GRANT: begin
        if (out_free) begin
          ram_we              = 1'b1;
          valid_d[free_idx_q] = 1'b1;
          cnt_d[cat_q]        = cnt_sel + CNT_W'(1);
          // id counter skips zero on wrap
          next_id_d = (next_id_q == {ID_WIDTH{1'b1}}) ? ID_FIRST : next_id_q + ID_FIRST;
          out_load   = 1'b1;
          out_kind_d = KIND_GRANT;
          out_id_d   = VID_W'(next_id_q);
          out_cat_d  = cat_q;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      cnt_q       <= '{default: '0};
      next_id_q   <= ID_FIRST;
      iss_q       <= '0;
      d_vld_q     <= 1'b0;
      vic_vld_q   <= 1'b0;
      free_vld_q  <= 1'b0;
      fnd_vld_q   <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      func_q      <= FUNC_PLAY;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      next_id_q   <= next_id_d;
      iss_q       <= iss_d;
      d_vld_q     <= d_vld_d;
      vic_vld_q   <= vic_vld_d;
      free_vld_q  <= free_vld_d;
      fnd_vld_q   <= fnd_vld_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
      func_q      <= func_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cat_q      <= cat_d;
    prio_q     <= prio_d;
    vid_q      <= vid_d;
    d_idx_q    <= d_idx_d;
    best_q     <= best_d;
    vic_idx_q  <= vic_idx_d;
    vic_id_q   <= vic_id_d;
    free_idx_q <= free_idx_d;
    fnd_idx_q  <= fnd_idx_d;
    fnd_id_q   <= fnd_id_d;
    fnd_cat_q  <= fnd_cat_d;
    pend_id_q  <= pend_id_d;
    pend_cat_q <= pend_cat_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_cat_q  <= out_cat_d;
    out_last_q <= out_last_d;
  end

  // a new result never overwrites one the consumer has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // the slot ram is written only together with a grant result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (out_load && out_kind_d == KIND_GRANT && state_q == ST_GRANT))
    else $error("slot write without grant");

  // the sweep pauses only while the result register is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> (out_valid_q && !out_ready_i && !ram_re))
    else $error("sweep stalled with free output");

  // an accepted item always starts a sweep from slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SCAN && iss_q == '0 && !d_vld_q))
    else $error("sweep not started");

  // the id counter never hands out zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != '0)
    else $error("id counter reached zero");

endmodule

`default_nettype wire

// ----- hw/rtl/vaps_ram.sv -----
// generic single-port-write, registered-read memory
`default_nettype none

module vaps_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 51,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- test/voice_allocator_priority_steal_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the voice allocator: shadow voice table, scoreboard and drivers

import vaps_pkg::*;

// one result item as the block emits it
typedef struct packed {
  logic [KIND_W-1:0] kind;
  logic [VID_W-1:0]  vid;
  logic [CAT_W-1:0]  cat;
  logic              last;
} voice_result_t;

// shadow voice table: works out the results of each accepted command and
// checks the block's results against them in order
class voice_table_shadow;
  bit                  slot_busy  [NUM_SLOTS];
  logic [CAT_W-1:0]    slot_cat   [NUM_SLOTS];
  logic [PRIO_W-1:0]   slot_prio  [NUM_SLOTS];
  logic [ID_WIDTH-1:0] slot_vid   [NUM_SLOTS];
  logic [MAX_W-1:0]    cat_voices [NUM_CATS];
  logic [MAX_W-1:0]    cat_limit  [NUM_CATS];
  logic [NUM_CATS-1:0] play_enable;
  logic [ID_WIDTH-1:0] id_next;
  voice_result_t       awaited_results [$];
  int mismatches, items_taken, reg_writes;
  int grants, rejects, completions, steals, full_rejects;

  function new();
    foreach (slot_busy[s]) begin
      slot_busy[s] = 1'b0;
      slot_cat[s]  = '0;
      slot_prio[s] = '0;
      slot_vid[s]  = '0;
    end
    foreach (cat_voices[c]) begin
      cat_voices[c] = '0;
      cat_limit[c]  = MAX_RESET[c];
    end
    play_enable = ENABLE_RESET;
    id_next     = ID_FIRST;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAX_W-1:0] data);
    reg_writes++;
    if (idx < NUM_CATS)
      cat_limit[idx] = data;
    else if (idx == REG_ENABLE)
      play_enable = data;
  endfunction

  function void await_result(logic [KIND_W-1:0] kind, logic [VID_W-1:0] vid,
                             logic [CAT_W-1:0] cat, logic last);
    voice_result_t r;
    r.kind = kind;
    r.vid  = vid;
    r.cat  = cat;
    r.last = last;
    awaited_results = {awaited_results, r};
  endfunction

  function void free_voice(int s);
    logic [CAT_W-1:0] c;
    c = slot_cat[s];
    slot_busy[s] = 1'b0;
    if (c < NUM_CATS && cat_voices[c] > 0)
      cat_voices[c]--;
  endfunction

  function void predict_play(logic [CAT_W-1:0] cat, logic [PRIO_W-1:0] prio);
    int victim;
    int hole;
    logic [PRIO_W-1:0] lowest;
    logic [ID_WIDTH-1:0] granted;
    victim = -1;
    hole   = -1;
    if (cat >= NUM_CATS || !play_enable[cat]) begin
      await_result(KIND_REJECT, '0, cat, 1'b1);
      return;
    end
    // category full: weakest voice strictly below the request goes, lowest slot on a tie
    if (cat_voices[cat] >= cat_limit[cat]) begin
      lowest = prio;
      for (int s = 0; s < NUM_SLOTS; s++)
        if (slot_busy[s] && slot_cat[s] == cat && slot_prio[s] < lowest) begin
          lowest = slot_prio[s];
          victim = s;
        end
      if (victim < 0) begin
        await_result(KIND_REJECT, '0, cat, 1'b1);
        return;
      end
      await_result(KIND_DONE, slot_vid[victim], cat, 1'b0);
      free_voice(victim);
      steals++;
    end
    for (int s = 0; s < NUM_SLOTS && hole < 0; s++)
      if (!slot_busy[s])
        hole = s;
    if (hole < 0) begin
      full_rejects++;
      await_result(KIND_REJECT, '0, cat, 1'b1);
      return;
    end
    granted = id_next;
    id_next = id_next + 1'b1;
    if (id_next == '0)
      id_next = ID_FIRST;
    slot_busy[hole] = 1'b1;
    slot_cat[hole]  = cat;
    slot_prio[hole] = prio;
    slot_vid[hole]  = granted;
    cat_voices[cat]++;
    await_result(KIND_GRANT, granted, cat, 1'b1);
  endfunction

  function void note_item(func_e f, logic [CAT_W-1:0] cat, logic [PRIO_W-1:0] prio,
                          logic [VID_W-1:0] vid);
    int freed [$];
    bit found;
    items_taken++;
    found = 1'b0;
    case (f)
      FUNC_PLAY: predict_play(cat, prio);
      FUNC_RELEASE: begin
        for (int s = 0; s < NUM_SLOTS && !found; s++)
          if (slot_busy[s] && slot_vid[s] == vid) begin
            await_result(KIND_DONE, vid, slot_cat[s], 1'b1);
            free_voice(s);
            found = 1'b1;
          end
      end
      default: begin
        for (int s = 0; s < NUM_SLOTS; s++)
          if (slot_busy[s] && (f == FUNC_STOP_ALL || slot_cat[s] == cat))
            freed = {freed, s};
        foreach (freed[i]) begin
          await_result(KIND_DONE, slot_vid[freed[i]], slot_cat[freed[i]],
                       i == freed.size() - 1);
          free_voice(freed[i]);
        end
      end
    endcase
  endfunction

  function bit pick_live_id(output logic [VID_W-1:0] vid);
    int busy [$];
    vid = '0;
    foreach (slot_busy[s])
      if (slot_busy[s])
        busy = {busy, s};
    if (busy.size() == 0)
      return 1'b0;
    vid = slot_vid[busy[$urandom_range(busy.size() - 1)]];
    return 1'b1;
  endfunction

  task report_mismatch(string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task check_result(voice_result_t got);
    voice_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d id %0d category %0d last %0d",
                                got.kind, got.vid, got.cat, got.last));
      return;
    end
    want = awaited_results.pop_front();
    case (want.kind)
      KIND_GRANT:  grants++;
      KIND_REJECT: rejects++;
      default:     completions++;
    endcase
    if (got.kind != want.kind)
      report_mismatch($sformatf("kind %0d, awaited %0d (id %0d)", got.kind, want.kind, want.vid));
    if (got.vid != want.vid)
      report_mismatch($sformatf("voice id %0d, awaited %0d", got.vid, want.vid));
    if (got.cat != want.cat)
      report_mismatch($sformatf("category %0d, awaited %0d (id %0d)", got.cat, want.cat, want.vid));
    if (got.last != want.last)
      report_mismatch($sformatf("last %0d, awaited %0d (id %0d)", got.last, want.last, want.vid));
  endtask

  task final_check();
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
  endtask
endclass

module voice_allocator_priority_steal_tb;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 9;
  // wait well past one full sweep of the slot table
  localparam int SETTLE_CYCLES = 120;
  // long output hold-off so the block fills up and stalls its input
  localparam int HOLD_CYCLES   = 800;
  localparam int CYCLE_LIMIT   = 1_000_000;
  // register indexes past the enable mask; the block ignores writes there
  localparam logic [CFG_IDX_W-1:0] REG_IGNORED_LO = REG_ENABLE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORED_HI = '1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // command channel
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [1:0]          func_i         = FUNC_PLAY;
  logic [CAT_W-1:0]    category_i     = '0;
  logic [PRIO_W-1:0]   priority_req_i = '0;
  logic [VID_W-1:0]    voice_id_i     = '0;

  // result channel
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [KIND_W-1:0]   kind_o;
  logic [VID_W-1:0]    voice_id_res_o;
  logic [CAT_W-1:0]    category_res_o;
  logic                last_o;

  // config write channel
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [MAX_W-1:0]    cfg_data_i     = '0;

  voice_table_shadow board;

  // idling knobs, percent per cycle, changed between phases
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // each bump starts one long output hold-off
  int hold_requests  = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int settings_used  = 0;
  int cycle_count    = 0;

  voice_allocator_priority_steal dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .category_i     (category_i),
    .priority_req_i (priority_req_i),
    .voice_id_i     (voice_id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .voice_id_res_o (voice_id_res_o),
    .category_res_o (category_res_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor: every accepted result goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result({kind_o, voice_id_res_o, category_res_o, last_o});
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, board.awaited_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // offer one command item, with a random gap first, and note it once taken
  task automatic send_item(func_e f, logic [CAT_W-1:0] cat, logic [PRIO_W-1:0] prio,
                           logic [VID_W-1:0] vid);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    func_i         <= f;
    category_i     <= cat;
    priority_req_i <= prio;
    voice_id_i     <= vid;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(f, cat, prio, vid);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // sender pauses until every awaited result is in and the sweep has surely ended
  task automatic wait_idle();
    stop_sending();
    while (board.awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAX_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
  endtask

  // new setting of all registers, written only while the block is idle
  task automatic configure(logic [MAX_W-1:0] l0, logic [MAX_W-1:0] l1, logic [MAX_W-1:0] l2,
                           logic [MAX_W-1:0] l3, logic [MAX_W-1:0] l4, logic [MAX_W-1:0] l5,
                           logic [MAX_W-1:0] l6, logic [NUM_CATS-1:0] mask);
    logic [MAX_W-1:0] limits [NUM_CATS];
    limits = '{l0, l1, l2, l3, l4, l5, l6};
    wait_idle();
    for (int c = 0; c < NUM_CATS; c++)
      write_reg(CFG_IDX_W'(c), limits[c]);
    write_reg(REG_ENABLE, mask);
    // writes past the last register must leave everything alone
    write_reg(REG_IGNORED_LO, '1);
    write_reg(REG_IGNORED_HI, '0);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // priorities: full range, plus clusters that make ties and near-max values
  function automatic logic [PRIO_W-1:0] pick_priority();
    logic [PRIO_W-1:0] p;
    case ($urandom_range(3))
      0:       p = PRIO_W'($urandom);
      1:       p = PRIO_W'($urandom_range(3));
      2:       p = '1 - PRIO_W'($urandom_range(3));
      default: p = PRIO_W'($urandom_range(300));
    endcase
    return p;
  endfunction

  // random commands; plays take play_pct percent, releases mostly name live voices
  task automatic run_mixed(int count, int play_pct);
    logic [CAT_W-1:0] cat;
    logic [VID_W-1:0] vid;
    logic [VID_W-1:0] live;
    int roll;
    repeat (count) begin
      roll = $urandom_range(99);
      // now and then the unused category seven
      cat = ($urandom_range(19) == 0) ? CAT_W'(NUM_CATS) : CAT_W'($urandom_range(NUM_CATS - 1));
      vid = $urandom;
      if (roll < play_pct) begin
        send_item(FUNC_PLAY, cat, pick_priority(), vid);
      end else begin
        roll = $urandom_range(11);
        if (roll < 8) begin
          if ($urandom_range(4) != 0 && board.pick_live_id(live))
            vid = live;
          send_item(FUNC_RELEASE, cat, pick_priority(), vid);
        end else if (roll < 11) begin
          send_item(FUNC_STOP_CAT, CAT_W'($urandom_range(NUM_CATS)), pick_priority(), vid);
        end else begin
          send_item(FUNC_STOP_ALL, cat, pick_priority(), vid);
        end
      end
    end
  endtask

  initial begin
    board = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at reset limits: extremes, odd categories, unknown ids
    send_item(FUNC_PLAY, 3'd0, '0, '0);
    send_item(FUNC_PLAY, 3'd6, '1, '1);
    send_item(FUNC_PLAY, CAT_W'(NUM_CATS), 16'd5, '0);     // category above six
    send_item(FUNC_STOP_CAT, CAT_W'(NUM_CATS), '0, '0);    // frees nothing
    send_item(FUNC_RELEASE, 3'd0, '0, '1);                 // unknown id
    send_item(FUNC_RELEASE, 3'd0, '0, '0);
    // speech holds three voices; tie at the weakest priority
    send_item(FUNC_PLAY, 3'd5, 16'd100, '0);
    send_item(FUNC_PLAY, 3'd5, 16'd50, '0);
    send_item(FUNC_PLAY, 3'd5, 16'd50, '0);
    send_item(FUNC_PLAY, 3'd5, 16'd200, '0);               // steals the lower slot
    send_item(FUNC_PLAY, 3'd5, 16'd10, '0);                // nothing weaker
    send_item(FUNC_PLAY, 3'd5, 16'd50, '0);                // equal is not weaker
    send_item(FUNC_RELEASE, 3'd7, '1, 32'd2);
    send_item(FUNC_RELEASE, 3'd7, '1, 32'd2);              // already gone
    send_item(FUNC_STOP_CAT, 3'd5, '0, '0);
    send_item(FUNC_STOP_CAT, 3'd5, '0, '0);                // nothing to stop
    send_item(FUNC_PLAY, 3'd3, 16'd7, '0);
    send_item(FUNC_STOP_ALL, 3'd0, '0, '0);
    send_item(FUNC_STOP_ALL, 3'd0, '0, '0);                // nothing to stop

    // zero limit, a disabled category, limit of one
    configure(7'd0, 7'd1, 7'd64, 7'd127, 7'd10, 7'd3, 7'd5, 7'b1111011);
    send_item(FUNC_PLAY, 3'd0, '1, '0);
    send_item(FUNC_PLAY, 3'd2, '1, '0);
    send_item(FUNC_PLAY, 3'd1, '0, '0);
    send_item(FUNC_PLAY, 3'd1, '0, '0);
    send_item(FUNC_PLAY, 3'd1, 16'd1, '0);
    send_item(FUNC_STOP_ALL, 3'd0, '0, '0);

    // limits equal to the table size and nearly all plays, so the table runs full; no idling
    configure(7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64, '1);
    run_mixed(75, 100);
    run_mixed(15, 50);

    // tiny limits keep stealing busy; sender idles
    configure(7'd1, 7'd2, 7'd3, 7'd1, 7'd2, 7'd3, 7'd1, '1);
    send_idle_pct = 55;
    run_mixed(90, 65);

    // zero and largest limits, every other category disabled; receiver stalls
    configure(7'd0, 7'd5, 7'd15, 7'd20, 7'd10, 7'd3, 7'd127, 7'b1010101);
    send_idle_pct  = 0;
    recv_stall_pct = 55;
    run_mixed(80, 60);

    // reset limits again, both sides idle
    configure(7'd10, 7'd5, 7'd15, 7'd20, 7'd10, 7'd3, 7'd5, '1);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    run_mixed(80, 60);

    // back pressure: output held off while items keep coming
    configure(7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64, '1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = hold_requests + 1;
    run_mixed(60, 75);

    // every category disabled
    configure(7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2, '0);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    run_mixed(20, 60);

    wait_idle();
    board.final_check();
    $display("covered %0d command items and %0d register writes over %0d settings",
             board.items_taken, board.reg_writes, settings_used);
    $display("results: %0d grants, %0d steals, %0d rejections (%0d table full), %0d completions",
             board.grants, board.steals, board.rejects, board.full_rejects, board.completions);
    if (board.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/vaps_pkg.sv
hw/rtl/vaps_ram.sv
hw/rtl/voice_allocator_priority_steal.sv
test/voice_allocator_priority_steal_tb.sv
